FILE: hw/rtl/fcc_pkg.sv
package fcc_pkg;

    localparam int FCC_MAX_FRAME = 256;

    localparam int FCC_CFG_IDX_W  = 2;
    localparam int FCC_CFG_DATA_W = 8;

    localparam logic [FCC_CFG_IDX_W-1:0] CFG_EXTRA_MODE  = 2'd0;
    localparam logic [FCC_CFG_IDX_W-1:0] CFG_MSG_ID_POS  = 2'd1;
    localparam logic [FCC_CFG_IDX_W-1:0] CFG_TABLE_ID    = 2'd2;
    localparam logic [FCC_CFG_IDX_W-1:0] CFG_TABLE_EXTRA = 2'd3;

    localparam logic       CFG_EXTRA_MODE_RST  = 1'b1;
    localparam logic [7:0] CFG_MSG_ID_POS_RST  = 8'd5;
    localparam logic [7:0] CFG_TABLE_ID_RST    = 8'd0;
    localparam logic [7:0] CFG_TABLE_EXTRA_RST = 8'd0;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic       extra_mode;
        logic [7:0] msg_id_pos;
        logic [7:0] table_id;
        logic [7:0] table_extra;
    } t_fcc_cfg;

    typedef struct packed {
        logic        crc_ok;
        logic [15:0] crc;
    } t_fcc_res;

    // x.25 / mcrf4xx byte update
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

FILE: hw/rtl/frame_crc16_checker_top.sv
// frame crc-16 checker (x.25 / mcrf4xx, optional crc-extra)
//
// input channel: one frame byte per transaction on i_in_frame_byte, with
// i_in_last_byte marking the final byte of the frame. a transaction happens
// when i_in_valid is high and o_in_stall is low.
// output channel: one transaction per frame, given on the final byte, with
// o_out_crc_ok and o_out_computed_crc, taken when o_out_valid is high and
// i_out_stall is low.
// config port: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 extra_mode, 1 msg_id_pos, 2 table_id, 3 table_extra); write only idle.
// a final byte's result passes the input register and then the result register.
// throughput: one byte per cycle unless a final byte waits behind a stalled result,
// set by the crc byte updates between the input register and the result register.
// a stalled result holds the output register; the input register keeps
// moving non-final bytes and stalls only on a final byte behind a result
// still waiting. reset clears both registers, the frame state and the
// config registers to their defaults.
module frame_crc16_checker_top
    import fcc_pkg::*;
#(
    parameter int MAX_FRAME = FCC_MAX_FRAME
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_in_frame_byte,
    input  logic                      i_in_last_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_out_crc_ok,
    output logic [15:0]               o_out_computed_crc,
    input  logic                      i_cfg_we,
    input  logic [FCC_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FCC_CFG_DATA_W-1:0] i_cfg_data
);

    t_fcc_cfg    r_cfg;
    t_fcc_res    w_res;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic        r_out_ok;
    logic [15:0] r_out_crc;
    logic        w_adv;
    logic        w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.extra_mode  <= CFG_EXTRA_MODE_RST;
            r_cfg.msg_id_pos  <= CFG_MSG_ID_POS_RST;
            r_cfg.table_id    <= CFG_TABLE_ID_RST;
            r_cfg.table_extra <= CFG_TABLE_EXTRA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXTRA_MODE:  r_cfg.extra_mode  <= i_cfg_data[0];
                CFG_MSG_ID_POS:  r_cfg.msg_id_pos  <= i_cfg_data;
                CFG_TABLE_ID:    r_cfg.table_id    <= i_cfg_data;
                CFG_TABLE_EXTRA: r_cfg.table_extra <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign w_load     = w_adv && r_in_last;
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_frame_byte;
            r_in_last <= i_in_last_byte;
        end
    end

    fcc_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ok  <= w_res.crc_ok;
            r_out_crc <= w_res.crc;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_crc_ok       = r_out_ok;
    assign o_out_computed_crc = r_out_crc;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv && r_in_last))
        else $error("result without a final byte");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in_last && r_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_crc_ok)
                                       && $stable(o_out_computed_crc))
        else $error("stalled result changed");

endmodule

FILE: hw/rtl/fcc_frame.sv
module fcc_frame
    import fcc_pkg::*;
#(
    parameter int MAX_FRAME = FCC_MAX_FRAME
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_fcc_cfg   i_cfg,
    output t_fcc_res   o_res
);

    localparam int IW = $clog2(MAX_FRAME + 1);
    localparam int CW = (IW > 8) ? IW : 8;
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_FRAME);

    logic [15:0]   r_crc;
    logic [15:0]   n_crc;
    logic [7:0]    r_held0;
    logic [7:0]    r_held1;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [7:0]    r_extra;
    logic [7:0]    n_extra;
    logic          w_capture;
    logic          w_fold;
    logic          w_too_short;
    logic          w_too_long;
    logic [15:0]   w_final_crc;

    always_comb begin
        w_capture = (r_idx != MAX_IDX) && (CW'(r_idx) == CW'(i_cfg.msg_id_pos));
        if (w_capture) begin
            n_extra = (i_byte == i_cfg.table_id) ? i_cfg.table_extra : 8'h00;
        end else begin
            n_extra = r_extra;
        end
        w_fold = (r_idx >= IW'(2)) && !(i_cfg.extra_mode && (r_idx == IW'(2)));
        n_crc  = w_fold ? crc_fold(r_crc, r_held0) : r_crc;
        n_idx  = (r_idx != MAX_IDX) ? r_idx + IW'(1) : r_idx;

        w_final_crc = i_cfg.extra_mode ? crc_fold(n_crc, n_extra) : n_crc;
        w_too_short = i_cfg.extra_mode ? (r_idx < IW'(2)) : (r_idx == '0);
        w_too_long  = (r_idx == MAX_IDX);

        o_res.crc_ok = !w_too_short && !w_too_long
                       && (r_held1 == w_final_crc[15:8]) && (i_byte == w_final_crc[7:0]);
        o_res.crc    = w_too_short ? 16'h0000 : w_final_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_idx   <= '0;
            r_extra <= 8'h00;
        end else if (i_adv) begin
            if (i_last) begin
                r_crc   <= CRC_INIT;
                r_idx   <= '0;
                r_extra <= 8'h00;
            end else begin
                r_crc   <= n_crc;
                r_idx   <= n_idx;
                r_extra <= n_extra;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_held0 <= r_held1;
            r_held1 <= i_byte;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= MAX_IDX)
        else $error("byte index past saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_last |=> (r_idx == '0) && (r_crc == CRC_INIT) && (r_extra == 8'h00))
        else $error("frame state not cleared after last byte");

    a_ok_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.crc_ok |-> !w_too_short && !w_too_long)
        else $error("crc ok on a frame of bad length");

endmodule

FILE: sim/frame_crc16_checker_top_tb.sv
`timescale 1ns / 100ps

module frame_crc16_checker_top_tb;
    import fcc_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_frame_byte = 8'h00;
    logic        i_in_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_crc_ok;
    logic [15:0] o_out_computed_crc;
    logic                      i_cfg_we = 1'b0;
    logic [FCC_CFG_IDX_W-1:0]  i_cfg_index = CFG_EXTRA_MODE;
    logic [FCC_CFG_DATA_W-1:0] i_cfg_data = 8'h00;

    frame_crc16_checker_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_frame_byte    (i_in_frame_byte),
        .i_in_last_byte     (i_in_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_crc_ok       (o_out_crc_ok),
        .o_out_computed_crc (o_out_computed_crc),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // register mirror
    logic       cfg_mode = CFG_EXTRA_MODE_RST;
    logic [7:0] cfg_id_pos = CFG_MSG_ID_POS_RST;
    logic [7:0] cfg_tbl_id = CFG_TABLE_ID_RST;
    logic [7:0] cfg_tbl_extra = CFG_TABLE_EXTRA_RST;

    // frame state of the predictor
    logic [15:0] run_crc = CRC_INIT;
    logic [7:0]  tail_bytes [2] = '{8'h00, 8'h00};
    int unsigned frame_pos = 0;
    logic [7:0]  id_extra = 8'h00;

    t_frame_byte tx_bytes_q [$];
    t_fcc_res    crc_expect_q [$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned frames_seen = 0;
    int unsigned good_frames = 0;
    int unsigned short_frames = 0;
    int unsigned long_frames = 0;
    int unsigned err_count = 0;
    bit          calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // reflected 0x8408, one bit at a time
    function automatic logic [15:0] x25_update(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[k]) begin
                c = (c >> 1) ^ 16'h8408;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic predict_crc_byte(input logic [7:0] b, input logic last);
        int unsigned at;
        logic [15:0] sum;
        bit          short_f;
        bit          long_f;
        t_fcc_res    res;
        at = frame_pos;
        if (at < FCC_MAX_FRAME && at == cfg_id_pos) begin
            id_extra = (b == cfg_tbl_id) ? cfg_tbl_extra : 8'h00;
        end
        if (at >= 2 && !(cfg_mode && at == 2)) begin
            run_crc = x25_update(run_crc, tail_bytes[0]);
        end
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = b;
        if (at < FCC_MAX_FRAME) begin
            frame_pos = at + 1;
        end
        if (last) begin
            short_f = (at + 1) < (cfg_mode ? 3 : 2);
            long_f = at >= FCC_MAX_FRAME;
            sum = cfg_mode ? x25_update(run_crc, id_extra) : run_crc;
            res.crc_ok = !short_f && !long_f && tail_bytes[0] == sum[15:8]
                         && tail_bytes[1] == sum[7:0];
            res.crc = short_f ? 16'h0000 : sum;
            crc_expect_q.push_back(res);
            frames_seen++;
            good_frames += res.crc_ok;
            short_frames += short_f;
            long_frames += long_f;
            run_crc = CRC_INIT;
            tail_bytes = '{8'h00, 8'h00};
            frame_pos = 0;
            id_extra = 8'h00;
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_crc_byte(i_in_frame_byte, i_in_last_byte);
                bytes_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 6);
                    i_in_valid <= 1'b0;
                end else if (tx_bytes_q.size() > 0) begin
                    t_frame_byte nb;
                    nb = tx_bytes_q.pop_front();
                    i_in_frame_byte <= nb.data;
                    i_in_last_byte <= nb.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (crc_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, crc", o_out_computed_crc, 0);
                end else begin
                    t_fcc_res want;
                    want = crc_expect_q.pop_front();
                    if (o_out_crc_ok !== want.crc_ok) begin
                        report_mismatch("crc_ok", o_out_crc_ok, want.crc_ok);
                    end
                    if (o_out_computed_crc !== want.crc) begin
                        report_mismatch("computed_crc", o_out_computed_crc, want.crc);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                     || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("** frame_crc16_checker_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic last);
        t_frame_byte nb;
        nb.data = d;
        nb.last = last;
        tx_bytes_q.push_back(nb);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] body [$], input bit corrupt);
        logic [15:0] c;
        logic [7:0]  hit;
        c = CRC_INIT;
        hit = 8'h00;
        for (int i = 0; i < body.size(); i++) begin
            if (!(cfg_mode && i == 0)) begin
                c = x25_update(c, body[i]);
            end
            push_byte(body[i], 1'b0);
        end
        if (cfg_id_pos < body.size() && body[cfg_id_pos] == cfg_tbl_id) begin
            hit = cfg_tbl_extra;
        end
        if (cfg_mode) begin
            c = x25_update(c, hit);
        end
        if (corrupt) begin
            c[7:0] = c[7:0] ^ (8'h01 << $urandom_range(0, 7));
        end
        push_byte(c[15:8], 1'b0);
        push_byte(c[7:0], 1'b1);
    endtask

    task automatic well_formed(input int unsigned len, input bit corrupt);
        logic [7:0] body [$];
        for (int i = 0; i < len; i++) begin
            body.push_back(8'($urandom));
        end
        if (cfg_id_pos < len && $urandom_range(0, 1)) begin
            body[cfg_id_pos] = cfg_tbl_id;
        end
        queue_frame(body, corrupt);
    endtask

    task automatic queue_noise(input int unsigned len);
        for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom), i == len - 1);
        end
    endtask

    task automatic random_frames(input int unsigned count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                queue_noise($urandom_range(1, 6));
            end else begin
                well_formed($urandom_range(0, 16), pick == 1);
            end
        end
    endtask

    task automatic write_reg(input logic [FCC_CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_EXTRA_MODE:  cfg_mode = val[0];
            CFG_MSG_ID_POS:  cfg_id_pos = val;
            CFG_TABLE_ID:    cfg_tbl_id = val;
            CFG_TABLE_EXTRA: cfg_tbl_extra = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic m, input logic [7:0] pos, input logic [7:0] tid,
                              input logic [7:0] tex);
        write_reg(CFG_EXTRA_MODE, {7'd0, m});
        write_reg(CFG_MSG_ID_POS, pos);
        write_reg(CFG_TABLE_ID, tid);
        write_reg(CFG_TABLE_EXTRA, tex);
    endtask

    task automatic settle();
        while (!(bytes_taken == bytes_queued && crc_expect_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] body [$];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        body = {8'h00};
        queue_frame(body, 1'b0);
        body = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        queue_frame(body, 1'b0);
        body = {8'h00, 8'h01, 8'h80};
        queue_frame(body, 1'b1);
        settle();

        set_config(1'b0, 8'd3, 8'h55, 8'hAA);
        random_frames(12);
        settle();
        set_config(1'b1, 8'd0, 8'hFF, 8'hFF);
        random_frames(12);
        settle();
        set_config(1'b1, 8'd255, 8'h00, 8'h01);
        well_formed(254, 1'b0);
        well_formed(255, 1'b0);
        random_frames(6);
        settle();
        set_config(1'b1, 8'd2, 8'($urandom), 8'($urandom));
        random_frames(12);
        settle();
        set_config(1'b0, 8'd255, 8'hFF, 8'h00);
        well_formed(256, 1'b0);
        random_frames(8);
        settle();

        // no idling from here on
        calm = 1'b1;
        set_config(1'b1, 8'd5, 8'($urandom), 8'($urandom));
        random_frames(14);
        settle();

        $display("%0d frames checked: %0d checksum matches, %0d too short, %0d oversize",
                 frames_seen, good_frames, short_frames, long_frames);
        $display("%0d bytes sent over 7 register settings, both checksum modes", bytes_taken);
        if (err_count == 0 && crc_expect_q.size() == 0) begin
            $display("** frame_crc16_checker_top: PASSED **");
        end else begin
            $display("** frame_crc16_checker_top: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_frame.sv
hw/rtl/frame_crc16_checker_top.sv
sim/frame_crc16_checker_top_tb.sv
